### sv/tdc_pkg.sv
// Shared types and constants for the TTL dedup cache.
`timescale 1ns / 1ps
`default_nettype none
package tdc_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int COST_W   = 32;
    localparam int TIME_W   = 32;
    localparam int TTL_W    = 16;
    localparam int EXP_W    = TIME_W + 1;

    localparam logic [TTL_W-1:0] DEFAULT_TTL_RST = TTL_W'(60);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        MD_NONE,
        MD_LOOKUP,
        MD_INSERT
    } t_mode;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [COST_W-1:0]   cost;
        logic [EXP_W-1:0]    expiry;
    } t_entry;

    typedef struct packed {
        logic                found;
        logic                found_live;
        logic [SLOT_W-1:0]   found_idx;
        logic [HANDLE_W-1:0] handle;
        logic [COST_W-1:0]   cost;
        logic                vac_found;
        logic [SLOT_W-1:0]   vac_idx;
        logic [SLOT_W-1:0]   soon_idx;
    } t_scan_res;

endpackage
`default_nettype wire

### sv/ttl_dedup_cache_top.sv
// Top level of the TTL dedup cache: sequencer, valid bits, entry RAM, result register.
//
// Fully associative cache of SLOTS entries with expiry times, held in one entry RAM
// (key, handle, cost, expiry) plus one valid flop per slot.
// Input channel: i_in_valid / o_in_stall carries one request word (opcode, key, now,
// handle, cost, ttl). Output channel: o_out_valid / i_out_stall returns exactly one
// result word (hit, handle, cost) per request, in order.
// Config: i_cfg_we writes default_ttl (reset 60); write it only while the block is idle.
// Lookup and insert stream all SLOTS entries out of the RAM one per cycle, then move to
// a decision state that writes back the chosen slot or drops an expired match.
// Clear, no-op and ignored requests (zero key or handle) skip the scan and go straight
// to the decision state. One request is in flight at a time; the next word is taken
// the cycle after the result registers.
// Clear drops all valid bits at once, when it is accepted.
// Reset (synchronous, active low) clears the valid bits, the sequencer and the result
// valid flag; RAM contents are left as they are, and the scan ignores invalid slots.
// A stalled result holds in the output register; the next request is still accepted
// and scanned, and its decision waits until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module ttl_dedup_cache_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tdc_pkg::TTL_W-1:0]       i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic [tdc_pkg::KEY_W-1:0]       i_key,
    input  wire logic [tdc_pkg::TIME_W-1:0]      i_now,
    input  wire logic [tdc_pkg::HANDLE_W-1:0]    i_handle,
    input  wire logic [tdc_pkg::COST_W-1:0]      i_cost_in,
    input  wire logic [tdc_pkg::TTL_W-1:0]       i_ttl,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_hit,
    output logic [tdc_pkg::HANDLE_W-1:0]         o_handle_out,
    output logic [tdc_pkg::COST_W-1:0]           o_resp_cost
);

    localparam int CNT_W = tdc_pkg::SLOT_W + 1;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(tdc_pkg::SLOTS);

    // sequencer
    tdc_pkg::t_state                  r_state, n_state;
    tdc_pkg::t_mode                   r_mode, n_mode;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic                             r_rd_vld;
    logic [tdc_pkg::SLOT_W-1:0]       r_rd_idx;

    // request hold
    logic [tdc_pkg::KEY_W-1:0]        r_key;
    logic [tdc_pkg::TIME_W-1:0]       r_now;
    logic [tdc_pkg::HANDLE_W-1:0]     r_handle;
    logic [tdc_pkg::COST_W-1:0]       r_cost;
    logic [tdc_pkg::TTL_W-1:0]        r_ttl_eff;

    // config and valid bits
    logic [tdc_pkg::TTL_W-1:0]        r_default_ttl;
    logic [tdc_pkg::SLOTS-1:0]        r_slot_valid, n_slot_valid;

    // result register
    logic                             r_o_valid, n_o_valid;
    logic                             r_hit, n_hit;
    logic [tdc_pkg::HANDLE_W-1:0]     r_handle_out, n_handle_out;
    logic [tdc_pkg::COST_W-1:0]       r_resp_cost, n_resp_cost;

    logic                             w_accept;
    logic                             w_rd_en;
    logic                             w_scan_start;
    logic                             w_we;
    logic [tdc_pkg::SLOT_W-1:0]       w_target;
    tdc_pkg::t_entry                  w_wentry;
    tdc_pkg::t_entry                  w_rentry;
    tdc_pkg::t_scan_res               w_res;

    assign o_in_stall = (r_state != tdc_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_rd_en    = (r_state == tdc_pkg::ST_SCAN) && (r_cnt < CNT_END);
    assign w_scan_start = w_accept;

    // insert target: same key, else first vacant, else soonest-expiring live slot
    assign w_target = w_res.found     ? w_res.found_idx :
                      w_res.vac_found ? w_res.vac_idx   : w_res.soon_idx;

    assign w_wentry.key    = r_key;
    assign w_wentry.handle = r_handle;
    assign w_wentry.cost   = r_cost;
    assign w_wentry.expiry = {1'b0, r_now} + tdc_pkg::EXP_W'(r_ttl_eff);

    tdc_ram #(
        .WIDTH ($bits(tdc_pkg::t_entry)),
        .DEPTH (tdc_pkg::SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_target),
        .i_wdata (w_wentry),
        .i_re    (w_rd_en),
        .i_raddr (r_cnt[tdc_pkg::SLOT_W-1:0]),
        .o_rdata (w_rentry)
    );

    tdc_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_scan_start),
        .i_vld        (r_rd_vld),
        .i_idx        (r_rd_idx),
        .i_slot_valid (r_slot_valid[r_rd_idx]),
        .i_entry      (w_rentry),
        .i_key        (r_key),
        .i_now        (r_now),
        .o_res        (w_res)
    );

    // next state and outputs
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_cnt        = r_cnt;
        n_slot_valid = r_slot_valid;
        n_o_valid    = r_o_valid && i_out_stall;
        n_hit        = r_hit;
        n_handle_out = r_handle_out;
        n_resp_cost  = r_resp_cost;
        w_we         = 1'b0;
        case (r_state)
            tdc_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_mode  = tdc_pkg::MD_NONE;
                    n_state = tdc_pkg::ST_FIN;
                    if ((i_opcode == tdc_pkg::OP_LOOKUP) && (i_key != '0)) begin
                        n_mode  = tdc_pkg::MD_LOOKUP;
                        n_state = tdc_pkg::ST_SCAN;
                    end else if ((i_opcode == tdc_pkg::OP_INSERT) && (i_key != '0)
                                 && (i_handle != '0)) begin
                        n_mode  = tdc_pkg::MD_INSERT;
                        n_state = tdc_pkg::ST_SCAN;
                    end else if (i_opcode == tdc_pkg::OP_CLEAR) begin
                        n_slot_valid = '0;
                    end
                end
            end
            tdc_pkg::ST_SCAN: begin
                if (w_rd_en) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (!r_rd_vld) begin
                    // last entry has been folded into the scan result
                    n_state = tdc_pkg::ST_FIN;
                end
            end
            tdc_pkg::ST_FIN: begin
                // commit only when the result register can take the word
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid    = 1'b1;
                    n_hit        = 1'b0;
                    n_handle_out = '0;
                    n_resp_cost  = '0;
                    n_state      = tdc_pkg::ST_IDLE;
                    case (r_mode)
                        tdc_pkg::MD_LOOKUP: begin
                            if (w_res.found && w_res.found_live) begin
                                n_hit        = 1'b1;
                                n_handle_out = w_res.handle;
                                n_resp_cost  = w_res.cost;
                            end else if (w_res.found) begin
                                n_slot_valid[w_res.found_idx] = 1'b0;
                            end
                        end
                        tdc_pkg::MD_INSERT: begin
                            w_we                   = 1'b1;
                            n_slot_valid[w_target] = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = tdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tdc_pkg::ST_IDLE;
            r_mode        <= tdc_pkg::MD_NONE;
            r_cnt         <= '0;
            r_rd_vld      <= 1'b0;
            r_slot_valid  <= '0;
            r_default_ttl <= tdc_pkg::DEFAULT_TTL_RST;
            r_o_valid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_cnt        <= n_cnt;
            r_rd_vld     <= w_rd_en;
            r_slot_valid <= n_slot_valid;
            r_o_valid    <= n_o_valid;
            if (i_cfg_we) begin
                r_default_ttl <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= r_cnt[tdc_pkg::SLOT_W-1:0];
        r_hit        <= n_hit;
        r_handle_out <= n_handle_out;
        r_resp_cost  <= n_resp_cost;
        if (w_accept) begin
            r_key     <= i_key;
            r_now     <= i_now;
            r_handle  <= i_handle;
            r_cost    <= i_cost_in;
            r_ttl_eff <= (i_ttl == '0) ? r_default_ttl : i_ttl;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_hit        = r_hit;
    assign o_handle_out = r_handle_out;
    assign o_resp_cost  = r_resp_cost;

endmodule
`default_nettype wire

### sv/tdc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### sv/tdc_scan.sv
// Scan accumulator: first key match, first vacant slot, soonest-expiring live slot.
`timescale 1ns / 1ps
`default_nettype none
module tdc_scan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_vld,
    input  wire logic [tdc_pkg::SLOT_W-1:0]  i_idx,
    input  wire logic                        i_slot_valid,
    input  wire tdc_pkg::t_entry             i_entry,
    input  wire logic [tdc_pkg::KEY_W-1:0]   i_key,
    input  wire logic [tdc_pkg::TIME_W-1:0]  i_now,
    output tdc_pkg::t_scan_res               o_res
);

    tdc_pkg::t_scan_res              r_res, n_res;
    logic                            r_soon_found, n_soon_found;
    logic [tdc_pkg::EXP_W-1:0]       r_soon_exp, n_soon_exp;
    logic                            w_live;
    logic                            w_match;

    assign w_live  = i_entry.expiry > {1'b0, i_now};
    assign w_match = i_slot_valid && (i_entry.key == i_key);

    always_comb begin
        n_res        = r_res;
        n_soon_found = r_soon_found;
        n_soon_exp   = r_soon_exp;
        if (i_start) begin
            n_res        = '0;
            n_soon_found = 1'b0;
            n_soon_exp   = r_soon_exp;
        end else if (i_vld) begin
            // keep only the first matching slot
            if (w_match && !r_res.found) begin
                n_res.found      = 1'b1;
                n_res.found_live = w_live;
                n_res.found_idx  = i_idx;
                n_res.handle     = i_entry.handle;
                n_res.cost       = i_entry.cost;
            end
            if (!i_slot_valid || !w_live) begin
                if (!r_res.vac_found) begin
                    n_res.vac_found = 1'b1;
                    n_res.vac_idx   = i_idx;
                end
            end else if (!r_soon_found || (i_entry.expiry < r_soon_exp)) begin
                n_soon_found   = 1'b1;
                n_soon_exp     = i_entry.expiry;
                n_res.soon_idx = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res        <= '0;
            r_soon_found <= 1'b0;
        end else begin
            r_res        <= n_res;
            r_soon_found <= n_soon_found;
        end
        r_soon_exp <= n_soon_exp;
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

### sim/ttl_cache_checker.sv
// Scoreboard for the TTL dedup cache: shadow slot table, expected-result queue, compare.
`timescale 1ns / 1ps
module ttl_cache_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tdc_pkg::TTL_W-1:0]       i_cfg_wdata,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_stall,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic [tdc_pkg::KEY_W-1:0]       i_key,
    input  wire logic [tdc_pkg::TIME_W-1:0]      i_now,
    input  wire logic [tdc_pkg::HANDLE_W-1:0]    i_handle,
    input  wire logic [tdc_pkg::COST_W-1:0]      i_cost_in,
    input  wire logic [tdc_pkg::TTL_W-1:0]       i_ttl,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_stall,
    input  wire logic                            i_hit,
    input  wire logic [tdc_pkg::HANDLE_W-1:0]    i_handle_out,
    input  wire logic [tdc_pkg::COST_W-1:0]      i_resp_cost,
    output int                                   o_pending,
    output int                                   o_errors,
    output int                                   o_results,
    output int                                   o_hits
);
    import tdc_pkg::*;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] handle;
        logic [COST_W-1:0]   cost;
    } t_reply;

    // shadow copy of the slot table
    logic                shadow_valid  [SLOTS];
    logic [KEY_W-1:0]    shadow_key    [SLOTS];
    logic [HANDLE_W-1:0] shadow_handle [SLOTS];
    logic [COST_W-1:0]   shadow_cost   [SLOTS];
    logic [EXP_W-1:0]    shadow_expiry [SLOTS];
    logic [TTL_W-1:0]    ttl_default = DEFAULT_TTL_RST;

    t_reply reply_q[$];
    int     errors  = 0;
    int     results = 0;
    int     hits    = 0;

    function automatic int match_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (shadow_valid[i] && shadow_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic logic is_live(input int i, input logic [TIME_W-1:0] t);
        return shadow_expiry[i] > {1'b0, t};
    endfunction

    task automatic store_entry(input logic [KEY_W-1:0] k, input logic [TIME_W-1:0] t,
                               input logic [HANDLE_W-1:0] h, input logic [COST_W-1:0] c,
                               input logic [TTL_W-1:0] l);
        int               target;
        int               vacant;
        int               soonest;
        logic [TTL_W-1:0] life;
        target = match_slot(k);
        if (target < 0) begin
            vacant  = -1;
            soonest = -1;
            // first free or dead slot wins, else the live slot expiring first
            for (int i = 0; i < SLOTS; i++) begin
                if (!shadow_valid[i] || !is_live(i, t)) begin
                    if (vacant < 0)
                        vacant = i;
                end else if (soonest < 0 || shadow_expiry[i] < shadow_expiry[soonest]) begin
                    soonest = i;
                end
            end
            target = (vacant >= 0) ? vacant : soonest;
            if (target < 0)
                target = 0;
        end
        life = (l == '0) ? ttl_default : l;
        shadow_valid[target]  = 1'b1;
        shadow_key[target]    = k;
        shadow_handle[target] = h;
        shadow_cost[target]   = c;
        shadow_expiry[target] = {1'b0, t} + EXP_W'(life);
    endtask

    task automatic serve_request(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                 input logic [TIME_W-1:0] t, input logic [HANDLE_W-1:0] h,
                                 input logic [COST_W-1:0] c, input logic [TTL_W-1:0] l,
                                 output t_reply r);
        int idx;
        r = '0;
        case (op)
            OP_LOOKUP: begin
                if (k != '0) begin
                    idx = match_slot(k);
                    if (idx >= 0) begin
                        if (is_live(idx, t)) begin
                            r.hit    = 1'b1;
                            r.handle = shadow_handle[idx];
                            r.cost   = shadow_cost[idx];
                        end else begin
                            shadow_valid[idx] = 1'b0;
                        end
                    end
                end
            end
            OP_INSERT: begin
                if (k != '0 && h != '0)
                    store_entry(k, t, h, c, l);
            end
            OP_CLEAR: begin
                for (int i = 0; i < SLOTS; i++)
                    shadow_valid[i] = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                shadow_valid[i] = 1'b0;
            ttl_default = DEFAULT_TTL_RST;
            reply_q.delete();
        end else begin
            if (i_cfg_we)
                ttl_default = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                serve_request(i_opcode, i_key, i_now, i_handle, i_cost_in, i_ttl, got);
                reply_q.push_back(got);
            end
            if (i_out_valid === 1'b1 && !i_out_stall) begin
                results++;
                if (i_hit === 1'b1)
                    hits++;
                if (reply_q.size() == 0) begin
                    $error("result word with no request outstanding");
                    errors++;
                end else begin
                    want = reply_q.pop_front();
                    if (i_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, i_hit);
                        errors++;
                    end
                    if (i_handle_out !== want.handle) begin
                        $error("handle_out: expected %h, got %h", want.handle, i_handle_out);
                        errors++;
                    end
                    if (i_resp_cost !== want.cost) begin
                        $error("resp_cost: expected %h, got %h", want.cost, i_resp_cost);
                        errors++;
                    end
                end
            end
        end
        o_pending <= reply_q.size();
        o_errors  <= errors;
        o_results <= results;
        o_hits    <= hits;
    end

endmodule

### sim/testbench.sv
// Stimulus and verdict for the TTL dedup cache; ttl_cache_checker does the checking.
`timescale 1ns / 1ps
module testbench;
    import tdc_pkg::*;

    // opcode three is a no-op; the package has no name for it
    localparam logic [1:0]       OP_NOP          = 2'd3;
    localparam int               PHASES          = 8;
    localparam int               ITEMS_PER_PHASE = 125;
    // tail wait: the length of a full scan of SLOTS entries plus margin
    localparam int               TAIL_CYCLES     = SLOTS + 16;
    localparam logic [KEY_W-1:0] KEY_A           = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_W-1:0] KEY_B           = 64'hFEDC_BA98_7654_3210;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    logic [TTL_W-1:0]    cfg_wdata  = '0;
    logic                in_valid   = 1'b0;
    logic [1:0]          opcode     = OP_LOOKUP;
    logic [KEY_W-1:0]    key        = '0;
    logic [TIME_W-1:0]   now        = '0;
    logic [HANDLE_W-1:0] handle     = '0;
    logic [COST_W-1:0]   cost_in    = '0;
    logic [TTL_W-1:0]    ttl        = '0;
    logic                out_stall  = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic                hit;
    logic [HANDLE_W-1:0] handle_out;
    logic [COST_W-1:0]   resp_cost;

    int pending;
    int errors;
    int results;
    int hits;

    // stimulus knobs, set per phase
    int   gap_pct     = 0;
    logic stall_on    = 1'b1;
    int   stall_left  = 0;
    int   run_left    = 0;
    int   n_lookups   = 0;
    int   n_inserts   = 0;
    int   n_other     = 0;

    logic [KEY_W-1:0]  key_pool [256];
    logic [TIME_W-1:0] clock_s = 32'd1000;

    always #5 clk = ~clk;

    ttl_dedup_cache_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_key        (key),
        .i_now        (now),
        .i_handle     (handle),
        .i_cost_in    (cost_in),
        .i_ttl        (ttl),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_hit        (hit),
        .o_handle_out (handle_out),
        .o_resp_cost  (resp_cost)
    );

    ttl_cache_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_key        (key),
        .i_now        (now),
        .i_handle     (handle),
        .i_cost_in    (cost_in),
        .i_ttl        (ttl),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_hit        (hit),
        .i_handle_out (handle_out),
        .i_resp_cost  (resp_cost),
        .o_pending    (pending),
        .o_errors     (errors),
        .o_results    (results),
        .o_hits       (hits)
    );

    // Result-side back-pressure: random stall bursts mixed with free-running stretches
    // of random length. Drop it entirely once stall_on goes low for the last phase.
    always @(posedge clk) begin
        if (!stall_on) begin
            out_stall <= 1'b0;
            stall_left = 0;
            run_left   = 0;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (run_left > 0) begin
            out_stall <= 1'b0;
            run_left--;
        end else if ($urandom_range(0, 2) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 14);
        end else begin
            out_stall <= 1'b0;
            run_left = $urandom_range(0, 60);
        end
    end

    // Present one request word and hold it until the block takes it. Valid stays
    // high into the next word unless a random gap is drawn, so back-to-back words
    // never see valid dropped and raised within one step.
    task automatic send_word(input logic [1:0] w_op, input logic [KEY_W-1:0] w_key,
                             input logic [TIME_W-1:0] w_now, input logic [HANDLE_W-1:0] w_handle,
                             input logic [COST_W-1:0] w_cost, input logic [TTL_W-1:0] w_ttl);
        opcode   <= w_op;
        key      <= w_key;
        now      <= w_now;
        handle   <= w_handle;
        cost_in  <= w_cost;
        ttl      <= w_ttl;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        case (w_op)
            OP_LOOKUP: n_lookups++;
            OP_INSERT: n_inserts++;
            default:   n_other++;
        endcase
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Wait until every expected result has come back, then let the block settle.
    // The first edge lets the checker count a word accepted at the current edge.
    task automatic wait_drained(input int settle);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    initial begin
        logic [1:0]          op;
        logic [KEY_W-1:0]    k;
        logic [HANDLE_W-1:0] h;
        logic [COST_W-1:0]   c;
        logic [TTL_W-1:0]    l;
        logic [TTL_W-1:0]    ttl_cfg;
        int                  r;
        int                  p;
        int                  n;
        int                  pool_n;
        int                  step_max;
        int                  ttl_max;
        int                  look_pct;
        int                  clear_pct;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words, run at the reset default ttl of 60.
        send_word(OP_LOOKUP, KEY_A, 32'd0, '0, '0, '0);         // miss on an empty table
        send_word(OP_INSERT, KEY_A, 32'd100, '1, '1, '0);       // ttl zero takes the default
        send_word(OP_LOOKUP, KEY_A, 32'd159, '0, '0, '0);       // last live second: hit
        send_word(OP_LOOKUP, '0, 32'd100, '0, '0, '0);          // zero key: miss
        send_word(OP_INSERT, '0, 32'd100, 32'd5, 32'd5, 16'd10);  // zero key: dropped
        send_word(OP_INSERT, KEY_B, 32'd100, '0, 32'd7, 16'd10);  // zero handle: dropped
        send_word(OP_LOOKUP, KEY_B, 32'd100, '0, '0, '0);
        send_word(OP_INSERT, KEY_A, 32'd0, 32'd1, '0, '1);      // overwrite the same key
        send_word(OP_LOOKUP, KEY_A, 32'd65534, '0, '0, '0);
        send_word(OP_LOOKUP, KEY_A, 32'd65535, '0, '0, '0);     // expired: frees the slot
        send_word(OP_LOOKUP, KEY_A, 32'd0, '0, '0, '0);         // freed, so a miss even now
        send_word(OP_INSERT, '1, '1, 32'h8000_0001, 32'h0001_0000, '1); // expiry past 2^32
        send_word(OP_LOOKUP, '1, '1, '0, '0, '0);
        send_word(OP_INSERT, KEY_B, 32'd10, 32'd2, 32'd3, 16'd1);
        send_word(OP_LOOKUP, KEY_B, 32'd11, '0, '0, '0);        // expiry equal to now is dead
        send_word(OP_INSERT, KEY_B, 32'd20, 32'd9, 32'd9, 16'd5);
        send_word(OP_NOP, KEY_B, 32'd20, 32'd9, 32'd9, 16'd5);
        send_word(OP_LOOKUP, KEY_B, 32'd24, '0, '0, '0);
        send_word(OP_CLEAR, '0, '0, '0, '0, '0);
        send_word(OP_LOOKUP, '1, 32'd0, '0, '0, '0);            // cleared: miss
        send_word(OP_LOOKUP, KEY_B, 32'd20, '0, '0, '0);

        // Random phases, each with its own default ttl and traffic shape.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    pool_n = 8;   step_max = 3;  ttl_max = 40;   look_pct = 50; clear_pct = 2;
                    gap_pct = 20; ttl_cfg = '1;
                end
                1: begin
                    // wide key set, slow clock, long lifetimes: fill and evict
                    pool_n = 100; step_max = 1;  ttl_max = 400;  look_pct = 30; clear_pct = 0;
                    gap_pct = 10; ttl_cfg = 16'd1;
                end
                2: begin
                    pool_n = 16;  step_max = 8;  ttl_max = 20;   look_pct = 50; clear_pct = 3;
                    gap_pct = 30; ttl_cfg = 16'd60;
                end
                3: begin
                    // default of zero: ttl-zero inserts are born expired
                    pool_n = 12;  step_max = 2;  ttl_max = 30;   look_pct = 50; clear_pct = 2;
                    gap_pct = 0;  ttl_cfg = '0;
                end
                4: begin
                    pool_n = 40;  step_max = 20; ttl_max = 300;  look_pct = 45; clear_pct = 1;
                    gap_pct = 15; ttl_cfg = TTL_W'($urandom_range(1, 65535));
                end
                5: begin
                    // frozen clock, short equal-ish lifetimes: eviction with ties
                    pool_n = 200; step_max = 0;  ttl_max = 8;    look_pct = 25; clear_pct = 0;
                    gap_pct = 20; ttl_cfg = 16'd5;
                end
                6: begin
                    // run the clock across the 32-bit wrap
                    pool_n = 24;  step_max = 5;  ttl_max = 60;   look_pct = 50; clear_pct = 2;
                    gap_pct = 25; ttl_cfg = 16'd30;
                    clock_s = 32'hFFFF_FFC0;
                end
                default: begin
                    // last phase: no idling on either side
                    pool_n = 10;  step_max = 4;  ttl_max = 50;   look_pct = 50; clear_pct = 2;
                    gap_pct = 0;  ttl_cfg = 16'd2;
                    stall_on <= 1'b0;
                end
            endcase
            for (n = 0; n < pool_n; n++) begin
                key_pool[n] = {$urandom, $urandom};
                if (key_pool[n] == '0)
                    key_pool[n] = 64'd1;
            end

            // drain, then write the register while the block is idle
            in_valid <= 1'b0;
            wait_drained(4);
            cfg_wdata <= ttl_cfg;
            cfg_we    <= 1'b1;
            @(posedge clk);
            cfg_we <= 1'b0;

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = OP_NOP;
                else if (r < 3 + clear_pct)
                    op = OP_CLEAR;
                else if (r < 3 + clear_pct + look_pct)
                    op = OP_LOOKUP;
                else
                    op = OP_INSERT;

                // mostly keys from the pool so inserts and lookups meet
                r = $urandom_range(0, 99);
                if (r < 3)
                    k = '0;
                else if (r < 8)
                    k = {$urandom, $urandom};
                else
                    k = key_pool[$urandom_range(0, pool_n - 1)];

                h = ($urandom_range(0, 99) < 3) ? '0 : HANDLE_W'($urandom);
                r = $urandom_range(0, 9);
                c = (r == 0) ? '0 : (r == 1) ? '1 : COST_W'($urandom);

                // advance the clock; rarely jump anywhere, even backward
                if ($urandom_range(0, 99) == 0)
                    clock_s = $urandom;
                else
                    clock_s = clock_s + TIME_W'($urandom_range(0, step_max));

                r = $urandom_range(0, 99);
                if (r < 10)
                    l = '0;
                else if (r < 13)
                    l = TTL_W'($urandom);
                else
                    l = TTL_W'($urandom_range(1, ttl_max));

                send_word(op, k, clock_s, h, c, l);
            end
        end

        in_valid <= 1'b0;
        wait_drained(TAIL_CYCLES);

        $display("Ran %0d lookups, %0d inserts, %0d clears/no-ops over %0d default-ttl settings;",
                 n_lookups, n_inserts, n_other, PHASES);
        $display("checked %0d result words (%0d hits), %0d mismatches.", results, hits, errors);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("Timeout with %0d result words outstanding", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
